[src/kdpo_pkg.sv]
package kdpo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic [15:0] TICK_PERIOD_RST = 16'd655;
  localparam logic [19:0] INV_RADIUS_RST = 20'd40960;

  // Q0.20, Q16 and reciprocal constants
  localparam int INV_SQRT3_Q20 = 605396;
  localparam int GAIN_Q20 = 636751;
  localparam int HEAD_K_Q16 = 166886;
  localparam int RECIP3_VX = 1398102;   // ceil(2^22/3)
  localparam int RECIP3_OM = 89478486;  // ceil(2^28/3)

  // register map, word index from paddr[2]
  localparam logic REG_TICK_PERIOD = 1'b0;
  localparam logic REG_INV_RADIUS = 1'b1;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [15:0] back_speed;
    logic               clear_distance;
  } kdpo_item_t;

  typedef struct packed {
    logic signed [15:0] velocity_x;
    logic signed [15:0] velocity_y;
    logic signed [23:0] yaw_rate;
    logic        [31:0] heading_angle;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [31:0] distance_total;
  } kdpo_result_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MULT = 5'b00010,
    S_ROT  = 5'b00100,
    S_VEC  = 5'b01000,
    S_OUT  = 5'b10000
  } kdpo_state_t;

  typedef enum logic [3:0] {
    OP_VY   = 4'd0,
    OP_OMS  = 4'd1,
    OP_VX   = 4'd2,
    OP_OMQ  = 4'd3,
    OP_H1   = 4'd4,
    OP_H2   = 4'd5,
    OP_H3   = 4'd6,
    OP_PREP = 4'd7,
    OP_GX   = 4'd8,
    OP_GY   = 4'd9,
    OP_GM   = 4'd10,
    OP_PX   = 4'd11,
    OP_PY   = 4'd12,
    OP_DIST = 4'd13
  } kdpo_op_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) return 24'sh7fffff;
    if (v < -28'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

[src/kiwi_drive_pose_odometry_top.sv]
// Dead-reckoning odometry for a three-wheel omni base. Each accepted word carries the three
// wheel speeds; the block works out body velocity and yaw rate, advances the heading, turns
// the velocity into the field frame by CORDIC rotation and adds it, times the tick period,
// to the pose, then adds the CORDIC magnitude times the tick period to a saturating distance
// total. All arithmetic goes through one shared 35x29 multiplier and one CORDIC
// micro-rotation stage. The work runs as 13 multiplier passes, a step to load the rotation
// and the two CORDIC runs of CORDIC_STEPS micro-rotations each. item_ready is low from
// acceptance until the result is taken, so a new word is not taken before the last result
// is taken. tick_period and inverse_radius sit at 0x0 and 0x4.
module kiwi_drive_pose_odometry_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  kdpo_pkg::kdpo_item_t  item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output kdpo_pkg::kdpo_result_t result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import kdpo_pkg::*;

  kdpo_state_t state;
  kdpo_op_t    op;
  logic [CNT_W-1:0] cnt;

  logic [15:0] tick_period;
  logic [19:0] inverse_radius;

  kdpo_item_t item_q;
  logic signed [15:0] vel_x, vel_y;
  logic signed [23:0] yaw;
  logic signed [26:0] om_sh;
  logic [39:0] p1;
  logic [47:0] hprod;
  logic [31:0] heading;
  logic [47:0] pos_x, pos_y, dist_acc;
  logic signed [33:0] ux, uy, cx, cy;
  logic signed [32:0] uz;
  logic signed [31:0] gx, gy, gm;

  // input arithmetic
  logic signed [16:0] diff_rl;
  logic signed [17:0] sum_lrb;
  logic signed [19:0] s2;
  logic [19:0] vx_m;
  logic [27:0] om_m;

  assign diff_rl = 17'(item_q.right_speed) - 17'(item_q.left_speed);
  assign sum_lrb = 18'(item_q.left_speed) + 18'(item_q.right_speed)
                 + 18'(item_q.back_speed);
  assign s2 = (20'(item_q.back_speed) <<< 1) - 20'(item_q.left_speed)
            - 20'(item_q.right_speed);
  // offset so the floor division sees a positive value: a multiple of three for om, one more for vx
  assign vx_m = s2 + 20'sd393217;
  assign om_m = 28'(om_sh) + 28'd100663296;

  // shared multiplier
  logic signed [34:0] mul_a;
  logic signed [28:0] mul_b;
  logic signed [63:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_VY: begin
        mul_a = 35'(diff_rl);
        mul_b = 29'(INV_SQRT3_Q20);
      end
      OP_OMS: begin
        mul_a = 35'(sum_lrb);
        mul_b = 29'(inverse_radius);
      end
      OP_VX: begin
        mul_a = 35'(vx_m);
        mul_b = 29'(RECIP3_VX);
      end
      OP_OMQ: begin
        mul_a = 35'(om_m);
        mul_b = 29'(RECIP3_OM);
      end
      OP_H1: begin
        mul_a = 35'(yaw);
        mul_b = 29'(tick_period);
      end
      OP_H2: begin
        mul_a = 35'(p1[23:0]);
        mul_b = 29'(HEAD_K_Q16);
      end
      OP_H3: begin
        mul_a = 35'($signed(p1[39:24]));
        mul_b = 29'(HEAD_K_Q16);
      end
      OP_GX: begin
        mul_a = 35'(cx);
        mul_b = 29'(GAIN_Q20);
      end
      OP_GY: begin
        mul_a = 35'(cy);
        mul_b = 29'(GAIN_Q20);
      end
      OP_GM: begin
        mul_a = 35'(ux);
        mul_b = 29'(GAIN_Q20);
      end
      OP_PX: begin
        mul_a = 35'(gx);
        mul_b = 29'(tick_period);
      end
      OP_PY: begin
        mul_a = 35'(gy);
        mul_b = 29'(tick_period);
      end
      OP_DIST: begin
        mul_a = 35'(gm);
        mul_b = 29'(tick_period);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  logic signed [63:0] t_q20, t_om, t_q10;
  logic signed [19:0] vx_w;
  logic signed [27:0] om_w;
  logic [47:0] head_full;
  logic [48:0] dist_sum;
  logic [47:0] dist_base, dist_new;

  assign t_q20 = prod + 64'sd524288;
  assign t_om  = prod + 64'sd6144;
  assign t_q10 = prod + 64'sd512;
  assign vx_w = $signed(prod[41:22]) - 20'sd131072;
  assign om_w = $signed({1'b0, prod[54:28]}) - 28'sd33554432;
  assign head_full = hprod + {prod[23:0], 24'd0} + 48'd32768;
  assign dist_base = item_q.clear_distance ? 48'd0 : dist_acc;
  assign dist_sum = {1'b0, dist_base} + {1'b0, t_q10[57:10]};
  assign dist_new = (dist_sum >= 49'h0_FFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : dist_sum[47:0];

  // CORDIC micro-rotation, shared by rotation and vectoring
  logic signed [33:0] vx14, vy14, sh_x, sh_y, x_new, y_new;
  logic signed [32:0] z_new;
  logic [4:0] atan_idx;
  logic turn_neg, quad_flip;

  assign vx14 = {{4{vel_x[15]}}, vel_x, 14'd0};
  assign vy14 = {{4{vel_y[15]}}, vel_y, 14'd0};
  assign quad_flip = heading[31] ^ heading[30];
  assign atan_idx = 5'(cnt);
  assign sh_x = ux >>> cnt;
  assign sh_y = uy >>> cnt;
  // rotation steers z to zero, vectoring steers y to zero
  assign turn_neg = (state == S_ROT) ? !uz[32] : uy[33];
  assign x_new = turn_neg ? ux - sh_y : ux + sh_y;
  assign y_new = turn_neg ? uy + sh_x : uy - sh_x;
  assign z_new = turn_neg ? uz - 33'(ATAN_TAB[atan_idx]) : uz + 33'(ATAN_TAB[atan_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_VY;
      cnt <= '0;
      tick_period <= TICK_PERIOD_RST;
      inverse_radius <= INV_RADIUS_RST;
      heading <= '0;
      pos_x <= '0;
      pos_y <= '0;
      dist_acc <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          REG_TICK_PERIOD: tick_period <= pwdata[15:0];
          REG_INV_RADIUS:  inverse_radius <= pwdata[19:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_q <= item;
            op <= OP_VY;
            state <= S_MULT;
          end
        end
        S_MULT: begin
          case (op)
            OP_VY: begin
              vel_y <= sat16(t_q20[39:20]);
              op <= OP_OMS;
            end
            OP_OMS: begin
              om_sh <= t_om[38:12];
              op <= OP_VX;
            end
            OP_VX: begin
              vel_x <= sat16(vx_w);
              op <= OP_OMQ;
            end
            OP_OMQ: begin
              yaw <= sat24(om_w);
              op <= OP_H1;
            end
            OP_H1: begin
              p1 <= prod[39:0];
              op <= OP_H2;
            end
            OP_H2: begin
              hprod <= prod[47:0];
              op <= OP_H3;
            end
            OP_H3: begin
              heading <= heading + head_full[47:16];
              op <= OP_PREP;
            end
            OP_PREP: begin
              // fold the heading into the right half-plane, negating the vector
              ux <= quad_flip ? -vx14 : vx14;
              uy <= quad_flip ? -vy14 : vy14;
              uz <= 33'($signed({heading[31] ^ quad_flip, heading[30:0]}));
              cnt <= '0;
              state <= S_ROT;
            end
            OP_GX: begin
              gx <= t_q20[51:20];
              op <= OP_GY;
            end
            OP_GY: begin
              gy <= t_q20[51:20];
              op <= OP_GM;
            end
            OP_GM: begin
              gm <= t_q20[51:20];
              op <= OP_PX;
            end
            OP_PX: begin
              pos_x <= pos_x + t_q10[57:10];
              op <= OP_PY;
            end
            OP_PY: begin
              pos_y <= pos_y + t_q10[57:10];
              op <= OP_DIST;
            end
            OP_DIST: begin
              dist_acc <= dist_new;
              op <= OP_VY;
              state <= S_OUT;
            end
            default: begin
              op <= OP_VY;
              state <= S_IDLE;
            end
          endcase
        end
        S_ROT: begin
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
            cx <= x_new;
            cy <= y_new;
            // load the vectoring pass, forced into the right half-plane
            ux <= vel_x[15] ? -vx14 : vx14;
            uy <= vel_x[15] ? -vy14 : vy14;
            cnt <= '0;
            state <= S_VEC;
          end else begin
            ux <= x_new;
            uy <= y_new;
            uz <= z_new;
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_VEC: begin
          ux <= x_new;
          uy <= y_new;
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
            cnt <= '0;
            op <= OP_GX;
            state <= S_MULT;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_OUT: begin
          if (result_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item_ready = (state == S_IDLE);
  assign result_valid = (state == S_OUT);
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_TICK_PERIOD: prdata = {16'd0, tick_period};
      REG_INV_RADIUS:  prdata = {12'd0, inverse_radius};
      default:         prdata = '0;
    endcase
  end

  assign result.velocity_x = vel_x;
  assign result.velocity_y = vel_y;
  assign result.yaw_rate = yaw;
  assign result.heading_angle = heading;
  assign result.pose_x = pos_x[47:16];
  assign result.pose_y = pos_y[47:16];
  assign result.distance_total = dist_acc[47:16];

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("input accepted while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("ready did not drop after a word was accepted");

  a_heading_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == S_MULT && op == OP_H3) |=> $stable(heading))
    else $error("heading changed outside its update step");

  a_dist_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULT && op == OP_DIST && !item_q.clear_distance) |=>
      dist_acc >= $past(dist_acc))
    else $error("distance total went down without a clear");

endmodule
